[hdl/cde_pkg.sv]
// Shared types and constants for the circular deque engine.
`timescale 1ns / 1ps

package cde_pkg;

    localparam int WORD_W   = 32;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;

    // Depth of the command queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_REAR  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_REAR   = 3'd3,
        OP_LIST       = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_POP_WAIT,
        BK_LIST
    } t_bk_state;

    // One decoded command as it travels from the front to the back.
    typedef struct packed {
        t_op               op;
        logic [WORD_W-1:0] value;
    } t_cmd;

    // One result item.
    typedef struct packed {
        t_status           status;
        logic [WORD_W-1:0] word;
        logic              last;
    } t_result;

    // Status of the back part, seen by the top level.
    typedef struct packed {
        logic empty;
        logic full;
        logic busy;
    } t_bk_stat;

endpackage

[hdl/cde_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module cde_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/cde_front.sv]
// Front part: accepts input transactions, decodes the opcode and queues commands.
`timescale 1ns / 1ps

module cde_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [cde_pkg::OP_W-1:0]   i_op,
    input  logic [cde_pkg::WORD_W-1:0] i_value,
    output logic                      o_cmd_valid,
    input  logic                      i_cmd_ready,
    output cde_pkg::t_cmd             o_cmd
);
    import cde_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_q [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    logic w_known;
    logic w_push;
    logic w_pop;

    // Opcodes outside the defined set are taken and dropped here.
    always_comb begin
        case (t_op'(i_op))
            OP_PUSH_FRONT, OP_PUSH_REAR, OP_POP_FRONT, OP_POP_REAR, OP_LIST: w_known = 1'b1;
            default: w_known = 1'b0;
        endcase
    end

    assign o_ready     = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd_ptr];

    assign w_push = i_valid && o_ready && w_known;
    assign w_pop  = o_cmd_valid && i_cmd_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= '{op: t_op'(i_op), value: i_value};
        end
    end

endmodule

[hdl/cde_back.sv]
// Back part: carries out deque commands against the store and drives the result register.
`timescale 1ns / 1ps

module cde_back #(
    parameter int DEPTH = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cmd_valid,
    output logic                      o_cmd_ready,
    input  cde_pkg::t_cmd             i_cmd,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output cde_pkg::t_result          o_out,
    output cde_pkg::t_bk_stat         o_stat,
    output logic                      o_wr_en,
    output logic [$clog2(DEPTH)-1:0]  o_wr_addr,
    output logic [cde_pkg::WORD_W-1:0] o_wr_data,
    output logic                      o_rd_en,
    output logic [$clog2(DEPTH)-1:0]  o_rd_addr,
    input  logic [cde_pkg::WORD_W-1:0] i_rd_data
);
    import cde_pkg::*;

    localparam int AW = $clog2(DEPTH);

    function automatic logic [AW-1:0] idx_next(input logic [AW-1:0] i);
        return (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [AW-1:0] idx_prev(input logic [AW-1:0] i);
        return (i == '0) ? AW'(DEPTH - 1) : i - 1'b1;
    endfunction

    t_bk_state r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [AW-1:0] r_list_idx, n_list_idx;
    logic          r_empty, n_empty;
    logic          r_out_valid, n_out_valid;
    t_result       r_out;

    logic    w_full;
    logic    w_out_free;
    logic    w_load;
    logic    w_list_last;
    t_result w_res;

    assign w_full      = !r_empty && (idx_next(r_tail) == r_head);
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_list_last = (r_list_idx == r_tail);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_list_idx  <= '0;
            r_empty     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_list_idx  <= n_list_idx;
            r_empty     <= n_empty;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_list_idx  = r_list_idx;
        n_empty     = r_empty;
        o_cmd_ready = 1'b0;
        o_wr_en     = 1'b0;
        o_wr_addr   = '0;
        o_wr_data   = i_cmd.value;
        o_rd_en     = 1'b0;
        o_rd_addr   = '0;
        w_load      = 1'b0;
        w_res       = '{status: ST_OK, word: '0, last: 1'b1};

        case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid && w_out_free) begin
                    o_cmd_ready = 1'b1;
                    case (i_cmd.op)
                        OP_PUSH_FRONT, OP_PUSH_REAR: begin
                            w_load = 1'b1;
                            if (w_full) begin
                                w_res.status = ST_OVERFLOW;
                            end else begin
                                o_wr_en = 1'b1;
                                if (r_empty) begin
                                    // The first word always lands in entry zero.
                                    n_head    = '0;
                                    n_tail    = '0;
                                    n_empty   = 1'b0;
                                    o_wr_addr = '0;
                                end else if (i_cmd.op == OP_PUSH_FRONT) begin
                                    n_head    = idx_prev(r_head);
                                    o_wr_addr = idx_prev(r_head);
                                end else begin
                                    n_tail    = idx_next(r_tail);
                                    o_wr_addr = idx_next(r_tail);
                                end
                            end
                        end
                        OP_POP_FRONT, OP_POP_REAR: begin
                            if (r_empty) begin
                                w_load       = 1'b1;
                                w_res.status = ST_UNDERFLOW;
                            end else begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = (i_cmd.op == OP_POP_FRONT) ? r_head : r_tail;
                                n_state   = BK_POP_WAIT;
                                if (r_head == r_tail) begin
                                    n_empty = 1'b1;
                                    n_head  = '0;
                                    n_tail  = '0;
                                end else if (i_cmd.op == OP_POP_FRONT) begin
                                    n_head = idx_next(r_head);
                                end else begin
                                    n_tail = idx_prev(r_tail);
                                end
                            end
                        end
                        OP_LIST: begin
                            if (r_empty) begin
                                w_load       = 1'b1;
                                w_res.status = ST_EMPTY;
                            end else begin
                                o_rd_en    = 1'b1;
                                o_rd_addr  = r_head;
                                n_list_idx = r_head;
                                n_state    = BK_LIST;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            BK_POP_WAIT: begin
                if (w_out_free) begin
                    w_load     = 1'b1;
                    w_res.word = i_rd_data;
                    n_state    = BK_IDLE;
                end
            end
            BK_LIST: begin
                // The read data for r_list_idx stays put until the next read is issued.
                if (w_out_free) begin
                    w_load     = 1'b1;
                    w_res.word = i_rd_data;
                    w_res.last = w_list_last;
                    if (w_list_last) begin
                        n_state = BK_IDLE;
                    end else begin
                        n_list_idx = idx_next(r_list_idx);
                        o_rd_en    = 1'b1;
                        o_rd_addr  = idx_next(r_list_idx);
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase

        n_out_valid = w_load ? 1'b1 : (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_stat      = '{empty: r_empty, full: w_full, busy: (r_state != BK_IDLE)};

endmodule

[hdl/circular_deque_engine.sv]
// Top level of the circular deque engine: front decoder, command queue, executor and store.
`timescale 1ns / 1ps

// This block keeps a double-ended queue of up to DEPTH signed 32-bit words in a
// circular store. Each input transaction carries an opcode in s_axis_tuser (push front,
// push rear, pop front, pop rear, list) and the word to push in s_axis_tdata. Every
// defined opcode produces result transactions on the m_axis side with a status in
// m_axis_tuser, a word in m_axis_tdata and m_axis_tlast on the final result of that
// command; undefined opcodes are accepted and produce nothing. A push to a full store
// reports overflow and leaves it alone, a pop from an empty store reports underflow,
// and a list of an empty store gives one result with status empty. The front part
// decodes and queues up to two commands, so input transactions keep flowing while the
// back part works or while a result waits to be taken. The back part runs one command
// at a time against a RAM with a registered read port: a push writes the store, a pop
// sends the address and then takes the read data, and a list makes one RAM read per
// listed word. Overflow, underflow and empty results need no access to the store.
// Results sit in one output register; a stalled m_axis_tready holds the back part.
// The store needs no clearing after reset, since a word is only read once written.
module circular_deque_engine #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] push_value
    input  logic [2:0]  s_axis_tuser,   // [2:0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] data_word
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    output logic        m_axis_tlast
);
    import cde_pkg::*;

    localparam int AW = $clog2(DEPTH);

    // Command channel between the front and the back.
    logic w_cmd_valid;
    logic w_cmd_ready;
    t_cmd w_cmd;

    // Result and store status from the back.
    t_result  w_out;
    t_bk_stat w_stat;

    // Store access.
    logic              w_wr_en;
    logic [AW-1:0]     w_wr_addr;
    logic [WORD_W-1:0] w_wr_data;
    logic              w_rd_en;
    logic [AW-1:0]     w_rd_addr;
    logic [WORD_W-1:0] w_rd_data;

    cde_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_op        (s_axis_tuser),
        .i_value     (s_axis_tdata),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready),
        .o_cmd       (w_cmd)
    );

    cde_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out       (w_out),
        .o_stat      (w_stat),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data)
    );

    cde_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign m_axis_tdata = w_out.word;
    assign m_axis_tuser = w_out.status;
    assign m_axis_tlast = w_out.last;

`ifndef SYNTHESIS
    // The store comes out of reset empty.
    a_reset_empty: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> w_stat.empty)
        else $error("store not empty after reset");

    // While a pop or a list is in progress, no further command is taken.
    a_busy_holds_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.busy |-> !w_cmd_ready)
        else $error("command taken while back part busy");

    // Every accepted defined opcode shows up as a queued command.
    a_cmd_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser <= OP_LIST)) |=> w_cmd_valid)
        else $error("accepted command missing from queue");
`endif

endmodule

[bench/circular_deque_checker.sv]
// Checker for the circular deque engine: watches both streams, predicts results and compares.
`timescale 1ns / 1ps

module circular_deque_checker #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_valid,
    input  logic        i_s_ready,
    input  logic [31:0] i_s_data,   // [31:0] push_value
    input  logic [2:0]  i_s_user,   // [2:0] opcode
    input  logic        i_m_valid,
    input  logic        i_m_ready,
    input  logic [31:0] i_m_data,   // [31:0] data_word
    input  logic [1:0]  i_m_user,   // [1:0] status
    input  logic        i_m_last,
    output int          o_mismatches,
    output int          o_pending
);
    import cde_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);

    // Shadow copy of the deque.
    logic [WORD_W-1:0] deque_words [DEPTH];
    logic [IDX_W-1:0]  front_idx;
    logic [IDX_W-1:0]  rear_idx;
    logic              deque_empty;

    // Results the block still owes, oldest first.
    t_result owed_results [$];
    int      mismatch_count;
    int      pending_count;

    assign o_mismatches = mismatch_count;
    assign o_pending    = pending_count;

    function automatic logic [IDX_W-1:0] wrap_up(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] wrap_down(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
    endfunction

    // Applies one command to the shadow deque and queues the results it causes.
    task automatic predict_command(input logic [2:0] op, input logic [WORD_W-1:0] val);
        logic [IDX_W-1:0]  i;
        logic              full;
        logic [WORD_W-1:0] word;
        full = !deque_empty && (wrap_up(rear_idx) == front_idx);
        case (op)
            OP_PUSH_FRONT, OP_PUSH_REAR: begin
                if (full) begin
                    owed_results.push_back('{status: ST_OVERFLOW, word: '0, last: 1'b1});
                end else begin
                    if (deque_empty) begin
                        front_idx      = '0;
                        rear_idx       = '0;
                        deque_empty    = 1'b0;
                        deque_words[0] = val;
                    end else if (op == OP_PUSH_FRONT) begin
                        front_idx              = wrap_down(front_idx);
                        deque_words[front_idx] = val;
                    end else begin
                        rear_idx              = wrap_up(rear_idx);
                        deque_words[rear_idx] = val;
                    end
                    owed_results.push_back('{status: ST_OK, word: '0, last: 1'b1});
                end
            end
            OP_POP_FRONT, OP_POP_REAR: begin
                if (deque_empty) begin
                    owed_results.push_back('{status: ST_UNDERFLOW, word: '0, last: 1'b1});
                end else begin
                    word = (op == OP_POP_FRONT) ? deque_words[front_idx]
                                                : deque_words[rear_idx];
                    if (front_idx == rear_idx) begin
                        deque_empty = 1'b1;
                        front_idx   = '0;
                        rear_idx    = '0;
                    end else if (op == OP_POP_FRONT) begin
                        front_idx = wrap_up(front_idx);
                    end else begin
                        rear_idx = wrap_down(rear_idx);
                    end
                    owed_results.push_back('{status: ST_OK, word: word, last: 1'b1});
                end
            end
            OP_LIST: begin
                if (deque_empty) begin
                    owed_results.push_back('{status: ST_EMPTY, word: '0, last: 1'b1});
                end else begin
                    i = front_idx;
                    for (int n = 0; n < DEPTH; n++) begin
                        owed_results.push_back('{status: ST_OK, word: deque_words[i],
                                                 last: (i == rear_idx)});
                        if (i == rear_idx) break;
                        i = wrap_up(i);
                    end
                end
            end
            default: ;  // Undefined opcodes are swallowed without a result.
        endcase
    endtask

    task automatic check_result(input t_result seen);
        t_result want;
        if (owed_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("unexpected result: status %0d word %h last %0d",
                         seen.status, seen.word, seen.last);
            return;
        end
        want = owed_results.pop_front();
        if (seen.status !== want.status || seen.word !== want.word
                || seen.last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch: expected %0d %h %0d, got %0d %h %0d",
                         want.status, want.word, want.last,
                         seen.status, seen.word, seen.last);
        end
    endtask

    initial begin
        mismatch_count = 0;
        pending_count  = 0;
        front_idx      = '0;
        rear_idx       = '0;
        deque_empty    = 1'b1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            front_idx   = '0;
            rear_idx    = '0;
            deque_empty = 1'b1;
            owed_results.delete();
        end else begin
            if (i_m_valid && i_m_ready)
                check_result('{status: t_status'(i_m_user), word: i_m_data, last: i_m_last});
            if (i_s_valid && i_s_ready)
                predict_command(i_s_user, i_s_data);
        end
        pending_count = owed_results.size();
    end

endmodule

[bench/tb_circular_deque_engine.sv]
// Testbench top for the circular deque engine: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps

// The bench drives commands into the slave stream and takes results from the master
// stream, while the checker beside the block predicts every result and compares it.
// A directed part walks through the empty and full corners, both overflows and
// underflows, a list of an empty and of a full store, and undefined opcodes. The
// random part then swings the fill level between empty and full in four phases of
// sender idling and receiver stalling. At the start of the random part the receiver
// holds off for a long stretch so that the block fills up and stalls its input.
module tb_circular_deque_engine;

    import cde_pkg::*;

    localparam int DEPTH          = 16;
    localparam int HOLD_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 20;
    localparam int DRAIN_CYCLES   = 40;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_data;    // [31:0] push_value
    logic [2:0]  s_user;    // [2:0] opcode
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_data;    // [31:0] data_word
    logic [1:0]  m_user;    // [1:0] status
    logic        m_last;

    int mismatches;
    int pending;

    // Percentages that shape the traffic, changed per phase by the stimulus.
    int sender_idle_pct;
    int receiver_stall_pct;

    // The stimulus asks once for a long receiver hold; the receiver process runs it.
    logic hold_request;
    logic hold_done;
    int   hold_left;

    int quiet_cycles;

    circular_deque_engine #(.DEPTH(DEPTH)) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tuser  (m_user),
        .m_axis_tlast  (m_last)
    );

    circular_deque_checker #(.DEPTH(DEPTH)) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_valid    (s_valid),
        .i_s_ready    (s_ready),
        .i_s_data     (s_data),
        .i_s_user     (s_user),
        .i_m_valid    (m_valid),
        .i_m_ready    (m_ready),
        .i_m_data     (m_data),
        .i_m_user     (m_user),
        .i_m_last     (m_last),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Offers one command and returns at the edge where its transaction completes.
    // Between commands the sender may go idle for a random number of cycles.
    task automatic offer_command(input logic [2:0] op, input logic [31:0] val);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= op;
        s_data  <= val;
        do @(posedge i_clk); while (!s_ready);
    endtask

    // Mostly random words, with the extremes of the signed range mixed in.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(15))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Receiver: random stalls per phase, plus the one long hold.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_request && !hold_done) begin
            m_ready   <= 1'b0;
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Watchdog: ends the run if no transaction moves on either side for too long.
    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        logic [2:0] op;
        logic       filling;
        int         roll;

        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        s_valid            = 1'b0;
        s_user             = '0;
        s_data             = '0;
        m_ready            = 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_request       = 1'b0;
        hold_done          = 1'b0;
        hold_left          = 0;
        quiet_cycles       = 0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: empty store first, then the only word popped again.
        offer_command(OP_LIST, 32'h0);
        offer_command(OP_POP_FRONT, 32'h0);
        offer_command(OP_POP_REAR, 32'hFFFF_FFFF);
        offer_command(OP_PUSH_FRONT, 32'h7FFF_FFFF);
        offer_command(OP_POP_REAR, 32'h0);
        offer_command(OP_PUSH_REAR, 32'h8000_0000);
        offer_command(OP_PUSH_FRONT, 32'hFFFF_FFFF);
        offer_command(OP_PUSH_REAR, 32'h0);
        // Fill to the brim from both ends so the indices wrap.
        for (int n = 0; n < DEPTH - 3; n++)
            offer_command((n % 2 == 0) ? OP_PUSH_FRONT : OP_PUSH_REAR, $urandom);
        offer_command(OP_PUSH_FRONT, 32'h1234_5678);
        offer_command(OP_PUSH_REAR, 32'h8765_4321);
        offer_command(OP_LIST, 32'h0);
        offer_command(OP_POP_FRONT, 32'h0);
        offer_command(OP_POP_REAR, 32'h0);
        offer_command(3'd5, 32'hAAAA_AAAA);
        offer_command(3'd6, 32'h5555_5555);
        offer_command(3'd7, 32'h0);

        // Random part: the fill level drifts up or down and the trend flips now
        // and then, so both the full and the empty corner are reached repeatedly.
        filling = 1'b1;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                    hold_request       = 1'b1;
                end
                1: begin
                    sender_idle_pct    = 72;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 72;
                end
                default: begin
                    sender_idle_pct    = 27;
                    receiver_stall_pct = 27;
                end
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(11) == 0)
                    filling = !filling;
                roll = $urandom_range(99);
                if (roll < (filling ? 62 : 25))
                    op = $urandom_range(1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
                else if (roll < 90)
                    op = $urandom_range(1) ? OP_POP_REAR : OP_POP_FRONT;
                else if (roll < 97)
                    op = OP_LIST;
                else
                    op = 3'($urandom_range(7, 5));
                offer_command(op, pick_word());
            end
        end
        s_valid <= 1'b0;
        @(posedge i_clk);

        // Let every owed result arrive, then watch a while for stray ones.
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
